>>> hdl/ccx_pkg.sv
package ccx_pkg;

    localparam int COORD_WIDTH      = 32;
    localparam int FRAC_BITS        = 16;
    localparam int GUARD_BITS       = 8;
    localparam int ANG_FRAC         = 30;
    localparam int ANG_W            = 36;
    localparam int DW               = 46;
    localparam int GAIN_W           = 21;
    localparam int PROD_W           = DW + GAIN_W + 1;
    localparam int CORDIC_STEPS_DEF = 20;
    localparam int QUEUE_DEPTH_DEF  = 2;
    localparam int CFG_IDX_W        = 8;
    localparam int CFG_DATA_W       = 32;

    localparam logic [GAIN_W-1:0]       INV_GAIN_Q20 = 21'd636751;
    localparam logic signed [ANG_W-1:0] PI_Q30       = 36'sd3373259426;

    localparam logic [2:0] AXIS_X     = 3'd0;
    localparam logic [2:0] AXIS_Y     = 3'd1;
    localparam logic [2:0] AXIS_Z     = 3'd2;
    localparam logic [2:0] AXIS_RAD   = 3'd3;
    localparam logic [2:0] AXIS_THETA = 3'd4;
    localparam logic [2:0] AXIS_PHI   = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_AXIS_MODE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIND_MIN  = 8'd1;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] point_x;
        logic signed [COORD_WIDTH-1:0] point_y;
        logic signed [COORD_WIDTH-1:0] point_z;
        logic                          last_point;
    } point_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] extreme_value;
        logic                          valid_res;
    } result_t;

    typedef struct packed {
        point_t     pt;
        logic [2:0] axis_mode;
        logic       find_min;
    } job_t;

    typedef struct packed {
        logic busy;
        logic pending;
    } back_status_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_START,
        BK_VEC,
        BK_ITER,
        BK_POST,
        BK_GAIN,
        BK_GAINR,
        BK_UPDATE
    } back_state_t;

    function automatic logic signed [ANG_W-1:0] atan_step(input logic [5:0] i);
        logic signed [ANG_W-1:0] r;
        case (i)
            6'd0:    r = 36'sd843314857;
            6'd1:    r = 36'sd497837829;
            6'd2:    r = 36'sd263043837;
            6'd3:    r = 36'sd133525159;
            6'd4:    r = 36'sd67021687;
            6'd5:    r = 36'sd33543516;
            6'd6:    r = 36'sd16775851;
            6'd7:    r = 36'sd8388437;
            6'd8:    r = 36'sd4194283;
            6'd9:    r = 36'sd2097149;
            default:
            begin
                if (i <= 6'd30)
                    r = ANG_W'(1) << (6'd30 - i);
                else
                    r = '0;
            end
        endcase
        return r;
    endfunction

endpackage

>>> hdl/ccx_queue.sv
module ccx_queue
    import ccx_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  job_t wr_data,
    output logic q_full,
    input  logic rd_en,
    output job_t rd_data,
    output logic q_valid,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH+1);

    job_t            mem [DEPTH];
    logic [PW-1:0]   wp_reg, rp_reg;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic            do_wr, do_rd;

    assign q_full  = (cnt_reg == CNTW'(DEPTH));
    assign q_valid = (cnt_reg != '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && q_valid;
    assign rd_data = mem[rp_reg];
    assign count   = cnt_reg;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_wr && !do_rd)
            cnt_next = cnt_reg + 1'b1;
        else if (!do_wr && do_rd)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wp_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (do_wr)
                wp_reg <= (wp_reg == PW'(DEPTH-1)) ? '0 : wp_reg + 1'b1;
            if (do_rd)
                rp_reg <= (rp_reg == PW'(DEPTH-1)) ? '0 : rp_reg + 1'b1;
        end
    end

endmodule

>>> hdl/ccx_front.sv
module ccx_front
    import ccx_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  point_t                point,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  q_wr,
    output job_t                  q_data,
    input  logic                  q_full
);

    logic [2:0] axis_mode_reg;
    logic       find_min_reg;

    assign cfg_ready = 1'b1;
    assign full      = q_full;
    assign q_wr      = push && !q_full;

    always_comb
    begin
        q_data.pt        = point;
        q_data.axis_mode = axis_mode_reg;
        q_data.find_min  = find_min_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_mode_reg <= AXIS_X;
            find_min_reg  <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_AXIS_MODE: axis_mode_reg <= cfg_data[2:0];
                CFG_FIND_MIN:  find_min_reg  <= cfg_data[0];
                default:       ;
            endcase
        end
    end

endmodule

>>> hdl/ccx_back.sv
module ccx_back
    import ccx_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         q_valid,
    input  job_t         q_data,
    output logic         q_rd,
    output logic         empty,
    input  logic         pop,
    output result_t      result,
    output back_status_t status
);

    localparam int CW = $clog2(CORDIC_STEPS);
    localparam int ASH = ANG_FRAC - FRAC_BITS;
    localparam logic signed [COORD_WIDTH-1:0] VMAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] VMIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    back_state_t state_reg, state_next;
    job_t        job_reg;
    logic signed [DW-1:0]     vin_x_reg, vin_y_reg, cx_reg, cy_reg;
    logic signed [ANG_W-1:0]  ca_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [CW-1:0]            cnt_reg;
    logic                     pass_reg, counted_reg;
    logic signed [COORD_WIDTH-1:0] val_reg, ext_reg;
    logic                     have_reg;
    logic                     out_valid_reg;
    result_t                  out_reg;

    logic signed [DW-1:0]     gx, gy, gz, xs, ys, rho;
    logic signed [ANG_W-1:0]  t;
    logic signed [ANG_W:0]    ang_sum;
    logic signed [COORD_WIDTH-1:0] ang_val, rad_val;
    logic signed [PROD_W-1:0] prod_rnd;
    logic signed [DW:0]       rad_rnd;
    logic                     origin, vzero, last_iter, out_free, better, is_last;

    assign gx = DW'(job_reg.pt.point_x) <<< GUARD_BITS;
    assign gy = DW'(job_reg.pt.point_y) <<< GUARD_BITS;
    assign gz = DW'(job_reg.pt.point_z) <<< GUARD_BITS;
    assign origin = (job_reg.pt.point_x == '0) && (job_reg.pt.point_y == '0)
                 && (job_reg.pt.point_z == '0);
    assign vzero = (vin_x_reg == '0) && (vin_y_reg == '0);
    assign xs = cx_reg >>> cnt_reg;
    assign ys = cy_reg >>> cnt_reg;
    assign t  = atan_step(6'(cnt_reg));
    assign last_iter = (cnt_reg == CW'(CORDIC_STEPS-1));

    assign ang_sum = (ANG_W+1)'(ca_reg) + (ANG_W+1)'(1 <<< (ASH-1));
    assign ang_val = COORD_WIDTH'(ang_sum >>> ASH);
    assign prod_rnd = (prod_reg + (PROD_W'(1) <<< 19)) >>> 20;
    assign rho = DW'(prod_rnd);
    assign rad_rnd = ((DW+1)'(rho) + (DW+1)'(1 <<< (GUARD_BITS-1))) >>> GUARD_BITS;
    assign rad_val = (rad_rnd > (DW+1)'(VMAX)) ? VMAX :
                     (rad_rnd < (DW+1)'(VMIN)) ? VMIN : COORD_WIDTH'(rad_rnd);

    assign is_last  = job_reg.pt.last_point;
    assign out_free = !out_valid_reg || pop;
    assign better   = job_reg.find_min ? (val_reg < ext_reg) : (val_reg > ext_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
                if (q_valid)
                    state_next = BK_START;
            BK_START:
            begin
                case (job_reg.axis_mode)
                    AXIS_RAD, AXIS_THETA: state_next = BK_VEC;
                    AXIS_PHI:             state_next = origin ? BK_UPDATE : BK_VEC;
                    default:              state_next = BK_UPDATE;
                endcase
            end
            BK_VEC:
                state_next = vzero ? BK_POST : BK_ITER;
            BK_ITER:
                if (last_iter)
                    state_next = BK_POST;
            BK_POST:
            begin
                if (job_reg.axis_mode == AXIS_THETA
                    || (pass_reg && job_reg.axis_mode == AXIS_PHI))
                    state_next = BK_UPDATE;
                else
                    state_next = BK_GAIN;
            end
            BK_GAIN:
                state_next = BK_GAINR;
            BK_GAINR:
                state_next = pass_reg ? BK_UPDATE : BK_VEC;
            BK_UPDATE:
                if (!is_last || out_free)
                    state_next = BK_IDLE;
            default:
                state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        q_rd           = (state_reg == BK_IDLE) && q_valid;
        empty          = !out_valid_reg;
        result         = out_reg;
        status.busy    = (state_reg != BK_IDLE);
        status.pending = have_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= BK_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            BK_IDLE:
                if (q_valid)
                    job_reg <= q_data;
            BK_START:
            begin
                vin_x_reg <= gx;
                vin_y_reg <= gy;
                pass_reg  <= 1'b0;
                case (job_reg.axis_mode)
                    AXIS_X:
                    begin
                        val_reg     <= job_reg.pt.point_x;
                        counted_reg <= 1'b1;
                    end
                    AXIS_Y:
                    begin
                        val_reg     <= job_reg.pt.point_y;
                        counted_reg <= 1'b1;
                    end
                    AXIS_Z:
                    begin
                        val_reg     <= job_reg.pt.point_z;
                        counted_reg <= 1'b1;
                    end
                    AXIS_RAD, AXIS_THETA: counted_reg <= 1'b1;
                    AXIS_PHI:             counted_reg <= !origin;
                    default:              counted_reg <= 1'b0;
                endcase
            end
            BK_VEC:
            begin
                cnt_reg <= '0;
                if (vzero)
                begin
                    cx_reg <= '0;
                    ca_reg <= '0;
                end
                else if (vin_x_reg < 0)
                begin
                    ca_reg <= (vin_y_reg >= 0) ? PI_Q30 : -PI_Q30;
                    cx_reg <= -vin_x_reg;
                    cy_reg <= -vin_y_reg;
                end
                else
                begin
                    ca_reg <= '0;
                    cx_reg <= vin_x_reg;
                    cy_reg <= vin_y_reg;
                end
            end
            BK_ITER:
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cy_reg >= 0)
                begin
                    cx_reg <= cx_reg + ys;
                    cy_reg <= cy_reg - xs;
                    ca_reg <= ca_reg + t;
                end
                else
                begin
                    cx_reg <= cx_reg - ys;
                    cy_reg <= cy_reg + xs;
                    ca_reg <= ca_reg - t;
                end
            end
            BK_POST:
                val_reg <= ang_val;
            BK_GAIN:
                prod_reg <= PROD_W'(cx_reg) * PROD_W'(signed'({1'b0, INV_GAIN_Q20}));
            BK_GAINR:
            begin
                pass_reg <= 1'b1;
                if (pass_reg)
                    val_reg <= rad_val;
                else if (job_reg.axis_mode == AXIS_PHI)
                begin
                    vin_x_reg <= gz;
                    vin_y_reg <= rho;
                end
                else
                begin
                    vin_x_reg <= rho;
                    vin_y_reg <= gz;
                end
            end
            default: ;
        endcase
        if (state_reg == BK_UPDATE && is_last && out_free)
        begin
            out_reg.valid_res     <= have_reg || counted_reg;
            out_reg.extreme_value <= counted_reg && (!have_reg || better) ? val_reg :
                                     (have_reg ? ext_reg : '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg      <= 1'b0;
            ext_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == BK_UPDATE && is_last && out_free)
                out_valid_reg <= 1'b1;
            else if (pop && out_valid_reg)
                out_valid_reg <= 1'b0;
            if (state_reg == BK_UPDATE && (!is_last || out_free))
            begin
                if (is_last)
                begin
                    have_reg      <= 1'b0;
                    ext_reg       <= '0;
                end
                else if (counted_reg)
                begin
                    have_reg <= 1'b1;
                    if (!have_reg || better)
                        ext_reg <= val_reg;
                end
            end
        end
    end

endmodule

>>> hdl/cell_coordinate_extremum_top.sv
// Points are processed one at a time by the single shared CORDIC iteration unit,
// one rotation per cycle; x/y/z need no CORDIC, theta takes one vectoring pass,
// phi and radius take two; a zero vector skips the iterations of its pass.
// The back end takes a new point only when idle, and a cell's last point waits until
// the previous result is popped; a QUEUE_DEPTH-entry queue (two by default) decouples input.
// Reset: asynchronous, active low; clears queue, config, running extreme.
module cell_coordinate_extremum_top
    import ccx_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
    parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  point_t                point,
    output logic                  empty,
    input  logic                  pop,
    output result_t               result,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic         q_wr, q_full, q_rd, q_valid;
    job_t         q_in, q_out;
    logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;
    back_status_t bstat;

    ccx_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .point     (point),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_wr      (q_wr),
        .q_data    (q_in),
        .q_full    (q_full)
    );

    ccx_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_wr),
        .wr_data (q_in),
        .q_full  (q_full),
        .rd_en   (q_rd),
        .rd_data (q_out),
        .q_valid (q_valid),
        .count   (q_count)
    );

    ccx_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_data  (q_out),
        .q_rd    (q_rd),
        .empty   (empty),
        .pop     (pop),
        .result  (result),
        .status  (bstat)
    );

    a_empty_cell_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !result.valid_res) |-> (result.extreme_value == '0))
        else $error("empty cell result carries nonzero value");

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (q_count <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH)))
        else $error("queue count above depth");

    a_full_matches: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> (q_count != '0))
        else $error("full with empty queue");

    a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_rd |-> !bstat.busy)
        else $error("queue read while back end busy");

endmodule

>>> sim/cell_coordinate_extremum_top_test.sv
`timescale 1ns / 1ps

module cell_coordinate_extremum_top_test;
    import ccx_pkg::*;

    localparam logic [2:0] AXIS_UNUSED_6 = 3'd6;
    localparam logic [2:0] AXIS_UNUSED_7 = 3'd7;
    localparam int DRAIN_CYCLES = 150;
    localparam int HOLD_CYCLES  = 400;
    localparam int CYCLE_LIMIT  = 600000;
    localparam longint RAD_MAX  = 64'sd2147483647;

    logic                  clk;
    logic                  rst_n;
    logic                  push;
    logic                  full;
    point_t                point;
    logic                  empty;
    logic                  pop;
    result_t               result;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    cell_coordinate_extremum_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .point     (point),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor state
    logic [2:0] pred_axis;
    logic       pred_min;
    longint     cell_ext;
    bit         cell_has_ext;
    result_t    cell_extremes_q[$];

    int  fail_count;
    int  cycle_count;
    bit  idle_on;
    bit  hold_req;
    bit  hold_active;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("** cell_coordinate_extremum_top: FAILED **");
                $finish;
            end
        end
    end

    function automatic longint rnd_shift(input longint v, input int s);
        if (s == 0)
            return v;
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint gain_scale(input longint v);
        return rnd_shift(v * 64'sd636751, 20);
    endfunction

    function automatic longint atan_q30(input int i);
        longint tbl [10] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                             33543516, 16775851, 8388437, 4194283, 2097149};
        if (i < 10)
            return tbl[i];
        return 64'sd1 <<< (30 - i);
    endfunction

    task automatic cordic_vector(input longint xi, input longint yi,
                                 output longint mag, output longint ang);
        longint x;
        longint y;
        longint a;
        longint xs;
        longint ys;
        x = xi;
        y = yi;
        a = 0;
        if (x == 0 && y == 0)
        begin
            mag = 0;
            ang = 0;
            return;
        end
        if (x < 0)
        begin
            a = (y >= 0) ? 64'sd3373259426 : -64'sd3373259426;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < CORDIC_STEPS_DEF; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0)
            begin
                x += ys;
                y -= xs;
                a += atan_q30(i);
            end
            else
            begin
                x -= ys;
                y += xs;
                a -= atan_q30(i);
            end
        end
        mag = x;
        ang = a;
    endtask

    task automatic track_extreme(input point_t p);
        longint x;
        longint y;
        longint z;
        longint m;
        longint a;
        longint rho;
        longint val;
        bit     counted;
        result_t r;
        x = longint'(p.point_x);
        y = longint'(p.point_y);
        z = longint'(p.point_z);
        val = 0;
        counted = 1'b1;
        case (pred_axis)
            AXIS_X: val = x;
            AXIS_Y: val = y;
            AXIS_Z: val = z;
            AXIS_RAD:
            begin
                cordic_vector(x <<< GUARD_BITS, y <<< GUARD_BITS, m, a);
                rho = gain_scale(m);
                cordic_vector(rho, z <<< GUARD_BITS, m, a);
                val = rnd_shift(gain_scale(m), GUARD_BITS);
                if (val > RAD_MAX)
                    val = RAD_MAX;
            end
            AXIS_THETA:
            begin
                cordic_vector(x <<< GUARD_BITS, y <<< GUARD_BITS, m, a);
                val = rnd_shift(a, ANG_FRAC - FRAC_BITS);
            end
            AXIS_PHI:
            begin
                if (x == 0 && y == 0 && z == 0)
                    counted = 1'b0;
                else
                begin
                    cordic_vector(x <<< GUARD_BITS, y <<< GUARD_BITS, m, a);
                    rho = gain_scale(m);
                    cordic_vector(z <<< GUARD_BITS, rho, m, a);
                    val = rnd_shift(a, ANG_FRAC - FRAC_BITS);
                end
            end
            default: counted = 1'b0;
        endcase
        if (counted)
        begin
            if (!cell_has_ext || (pred_min ? (val < cell_ext) : (val > cell_ext)))
                cell_ext = val;
            cell_has_ext = 1'b1;
        end
        if (p.last_point)
        begin
            r.extreme_value = cell_has_ext ? cell_ext[31:0] : '0;
            r.valid_res     = cell_has_ext;
            cell_extremes_q.push_back(r);
            cell_ext = 0;
            cell_has_ext = 1'b0;
        end
    endtask

    // result side
    initial
    begin
        result_t exp_r;
        pop <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && pop && !empty)
            begin
                if (cell_extremes_q.size() == 0)
                begin
                    $error("unexpected result beat: extreme_value %0d valid_res %0b",
                           result.extreme_value, result.valid_res);
                    fail_count++;
                end
                else
                begin
                    exp_r = cell_extremes_q.pop_front();
                    if (result.extreme_value !== exp_r.extreme_value)
                    begin
                        $error("extreme_value: expected %0d, actual %0d",
                               exp_r.extreme_value, result.extreme_value);
                        fail_count++;
                    end
                    if (result.valid_res !== exp_r.valid_res)
                    begin
                        $error("valid_res: expected %0b, actual %0b",
                               exp_r.valid_res, result.valid_res);
                        fail_count++;
                    end
                end
            end
            if (hold_active)
                pop <= 1'b0;
            else if (idle_on)
                pop <= ($urandom % 100) >= 35;
            else
                pop <= 1'b1;
        end
    end

    // long receiver hold-off
    initial
    begin
        hold_active = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_active = 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_active = 1'b0;
                hold_req = 1'b0;
            end
        end
    end

    task automatic send_point(input point_t p);
        while (idle_on && ($urandom % 100) < 35)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push  <= 1'b1;
        point <= p;
        do
            @(posedge clk);
        while (full);
        track_extreme(p);
    endtask

    task automatic send_xyz(input logic [31:0] x, input logic [31:0] y,
                            input logic [31:0] z, input bit last);
        point_t p;
        p.point_x    = x;
        p.point_y    = y;
        p.point_z    = z;
        p.last_point = last;
        send_point(p);
    endtask

    task automatic drain();
        push <= 1'b0;
        while (cell_extremes_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_AXIS_MODE)
            pred_axis = data[2:0];
        else if (idx == CFG_FIND_MIN)
            pred_min = data[0];
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom % 7)
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return '0;
            3: return 32'($signed($urandom_range(0, 32'h60000)) - 32'sh30000);
            default: return $urandom;
        endcase
    endfunction

    task automatic test_directed();
        write_reg(CFG_AXIS_MODE, AXIS_X);
        write_reg(CFG_FIND_MIN, 1);
        send_xyz(32'h7fffffff, 0, 0, 0);
        send_xyz(32'h80000000, 0, 0, 0);
        send_xyz(32'h00010000, 0, 0, 1);
        write_reg(CFG_FIND_MIN, 0);
        write_reg(CFG_AXIS_MODE, AXIS_Y);
        send_xyz(0, 32'h80000000, 0, 0);
        send_xyz(0, 32'h7fffffff, 0, 1);
        write_reg(CFG_AXIS_MODE, AXIS_Z);
        send_xyz(0, 0, 32'hffffffff, 0);
        send_xyz(0, 0, 32'hfffffffe, 1);
        write_reg(CFG_AXIS_MODE, AXIS_RAD);
        send_xyz(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0);
        send_xyz(32'h80000000, 32'h80000000, 32'h80000000, 0);
        send_xyz(0, 0, 0, 1);
        write_reg(CFG_AXIS_MODE, AXIS_THETA);
        send_xyz(0, 0, 0, 0);
        send_xyz(32'hffff0000, 0, 0, 0);
        send_xyz(32'hffff0000, 32'hffffffff, 0, 1);
        write_reg(CFG_AXIS_MODE, AXIS_PHI);
        send_xyz(0, 0, 0, 1);
        send_xyz(0, 0, 32'h00010000, 0);
        send_xyz(0, 0, 0, 0);
        send_xyz(0, 32'h00010000, 32'hffff0000, 1);
        write_reg(CFG_AXIS_MODE, AXIS_UNUSED_6);
        send_xyz(32'h00010000, 0, 0, 1);
        write_reg(CFG_AXIS_MODE, AXIS_UNUSED_7);
        send_xyz(32'h00010000, 0, 0, 1);
    endtask

    task automatic test_random_cells(input int n_items);
        int left;
        left = n_items;
        while (left > 0)
        begin
            for (int k = $urandom_range(1, 6); k > 0 && left > 0; k--)
            begin
                send_xyz(rand_coord(), rand_coord(), rand_coord(), k == 1 || left == 1);
                left--;
            end
        end
    endtask

    task automatic test_random_phases();
        logic [2:0] ax;
        for (int ph = 0; ph < 16; ph++)
        begin
            ax = ($urandom % 10 == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
            write_reg(CFG_AXIS_MODE, {29'($urandom_range(0, 32'h1fffffff)), ax});
            write_reg(CFG_FIND_MIN, $urandom);
            idle_on = (ph != 5);
            if (ph == 9)
                hold_req = 1'b1;
            test_random_cells(ph == 9 ? 30 : 60);
        end
        idle_on = 1'b1;
    endtask

    task automatic test_mid_cell_config();
        write_reg(CFG_AXIS_MODE, AXIS_X);
        write_reg(CFG_FIND_MIN, 0);
        send_xyz(32'h00020000, 32'h00050000, 0, 0);
        write_reg(CFG_AXIS_MODE, AXIS_Y);
        write_reg(CFG_FIND_MIN, 1);
        send_xyz(32'h00090000, 32'h00010000, 0, 1);
    endtask

    initial
    begin
        fail_count   = 0;
        idle_on      = 1'b1;
        hold_req     = 1'b0;
        pred_axis    = AXIS_X;
        pred_min     = 1'b1;
        cell_ext     = 0;
        cell_has_ext = 1'b0;
        rst_n     <= 1'b0;
        push      <= 1'b0;
        point     <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_mid_cell_config();
        test_random_phases();

        drain();
        if (fail_count == 0)
            $display("** cell_coordinate_extremum_top: PASSED **");
        else
            $display("** cell_coordinate_extremum_top: FAILED **");
        $finish;
    end

endmodule

>>> sim.f
hdl/ccx_pkg.sv
hdl/ccx_queue.sv
hdl/ccx_front.sv
hdl/ccx_back.sv
hdl/cell_coordinate_extremum_top.sv
sim/cell_coordinate_extremum_top_test.sv
